>>> rtl/mpsp_pkg.sv
package mpsp_pkg;

  // Field types of one request and one result
  typedef logic [3:0]        lines_t;
  typedef logic [2:0]        drive_t;
  typedef logic [9:0]        pressed_t;
  typedef logic signed [8:0] axis_t;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_ENABLE    = 2'd0;
  localparam cfg_idx_t CFG_BIT_DELAY = 2'd1;
  localparam cfg_idx_t CFG_CMD_DELAY = 2'd2;
  localparam cfg_idx_t CFG_REFRESH   = 2'd3;

  localparam logic [15:0] BIT_DELAY_RST = 16'd5;
  localparam logic [15:0] CMD_DELAY_RST = 16'd10;
  localparam logic [19:0] REFRESH_RST   = 20'd10000;

  // Line drive codes: bit0 command, bit1 select high, bit2 clock
  localparam drive_t DRV_IDLE   = 3'b110;
  localparam drive_t DRV_SEL_LO = 3'b100;

  // Pad answer checks
  localparam logic [7:0]  ID_OK        = 8'h41;
  localparam logic [7:0]  STATUS_OK    = 8'h5A;
  localparam logic [15:0] BTN_RELEASED = 16'hFFFF;

  localparam axis_t AXIS_POS  = 9'sd255;
  localparam axis_t AXIS_NEG  = -9'sd255;
  localparam axis_t AXIS_ZERO = 9'sd0;

  localparam logic [2:0] LAST_BYTE = 3'd4;

  // Command byte sent in each slot of the frame
  function automatic logic [7:0] cmd_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h01;
      3'd1:    b = 8'h42;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Full deflection toward the pressed direction, zero when both or neither
  function automatic axis_t axis_val(input logic plus, input logic minus);
    axis_t v;
    unique case ({plus, minus})
      2'b10:   v = AXIS_POS;
      2'b01:   v = AXIS_NEG;
      default: v = AXIS_ZERO;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/mpsp_in_if.sv
interface mpsp_in_if
  import mpsp_pkg::*;
();
  logic   valid;
  logic   ready;
  lines_t data_lines;

  modport source (output valid, output data_lines, input ready);
  modport sink   (input valid, input data_lines, output ready);
endinterface

>>> rtl/mpsp_out_if.sv
interface mpsp_out_if
  import mpsp_pkg::*;
();
  logic       valid;
  logic       ready;
  drive_t     drive_lines;
  logic       report_valid;
  logic [1:0] pad_index;
  logic       pad_ok;
  pressed_t   pressed;
  axis_t      axis_x;
  axis_t      axis_y;
  logic       last_report;

  modport source (
    output valid, output drive_lines, output report_valid, output pad_index,
    output pad_ok, output pressed, output axis_x, output axis_y, output last_report,
    input ready
  );
  modport sink (
    input valid, input drive_lines, input report_valid, input pad_index,
    input pad_ok, input pressed, input axis_x, input axis_y, input last_report,
    output ready
  );
endinterface

>>> rtl/multi_pad_serial_poller.sv
// Each tick result is registered and reaches out_res in the cycle after its acceptance.
// Throughput: one tick request per cycle, held off by a stalled output register.
// A report tick gives no plain result; its NUM_PADS reports leave the report
// unit one per cycle while the output is free, and hold off in_req meanwhile.
// Reset (rst_n low, synchronous): sequencer idle, counters clear, polling disabled,
// delays back to 5 / 10 / 10000 ticks, output register empty.
module multi_pad_serial_poller
  import mpsp_pkg::*;
#(
  parameter int NUM_PADS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  mpsp_in_if.sink           in_req,
  mpsp_out_if.source        out_res,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  cfg_data_t         cfg_wdata
);

  localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam logic [PAD_W-1:0] PAD_LAST = PAD_W'(NUM_PADS - 1);

  // Sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SEL_HI   = 3'd1;
  localparam logic [2:0] PH_SEL_LO   = 3'd2;
  localparam logic [2:0] PH_BIT_LO   = 3'd3;
  localparam logic [2:0] PH_BIT_HI   = 3'd4;
  localparam logic [2:0] PH_CMD_WAIT = 3'd5;
  localparam logic [2:0] PH_REPORT   = 3'd6;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        enable_r;
  logic [15:0] bit_delay_r;
  logic [15:0] cmd_delay_r;
  logic [19:0] refresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      bit_delay_r <= BIT_DELAY_RST;
      cmd_delay_r <= CMD_DELAY_RST;
      refresh_r   <= REFRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable_r    <= cfg_wdata[0];
        CFG_BIT_DELAY: bit_delay_r <= cfg_wdata[15:0];
        CFG_CMD_DELAY: cmd_delay_r <= cfg_wdata[15:0];
        CFG_REFRESH:   refresh_r   <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the report unit owns the output register while it drains
  // ---------------------------------------------------------------------------
  logic             rep_active_r;
  logic [PAD_W-1:0] rep_pad_r;
  logic             out_valid_r;
  logic             out_free;
  logic             in_acc;

  assign out_free     = !out_valid_r || out_res.ready;
  assign in_req.ready = !rep_active_r && out_free;
  assign in_acc       = in_req.valid && in_req.ready;

  // ---------------------------------------------------------------------------
  // Bit-level sequencer state; advances once per accepted tick
  // ---------------------------------------------------------------------------
  logic [2:0]  phase_r,   phase_nxt;
  logic [15:0] dly_r,     dly_nxt;
  logic [19:0] ref_r,     ref_nxt;
  logic [2:0]  byte_r,    byte_nxt;
  logic [2:0]  bit_r,     bit_nxt;
  logic [7:0]  shift_r   [NUM_PADS];
  logic [7:0]  shift_nxt [NUM_PADS];
  logic [7:0]  id_r      [NUM_PADS];
  logic [7:0]  id_nxt    [NUM_PADS];
  logic [7:0]  sts_r     [NUM_PADS];
  logic [7:0]  sts_nxt   [NUM_PADS];
  logic [15:0] btn_r     [NUM_PADS];
  logic [15:0] btn_nxt   [NUM_PADS];

  logic [16:0] dly_inc;
  logic [20:0] ref_inc;
  logic [15:0] bit_min;
  logic [7:0]  cmd_cur;
  logic        cbit;
  logic        bit_done;
  logic        fin;
  logic        start_rep;
  drive_t      drive;

  assign dly_inc = {1'b0, dly_r} + 17'd1;
  assign ref_inc = {1'b0, ref_r} + 21'd1;
  assign bit_min = (bit_delay_r == 16'd0) ? 16'd1 : bit_delay_r;
  assign cmd_cur = cmd_byte(byte_r);
  assign cbit    = cmd_cur[bit_r];
  // Clock-high half, select phases: count then compare, one tick at least
  assign bit_done = dly_inc >= {1'b0, bit_min};

  always_comb begin
    phase_nxt = phase_r;
    dly_nxt   = dly_r;
    ref_nxt   = ref_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    id_nxt    = id_r;
    sts_nxt   = sts_r;
    btn_nxt   = btn_r;
    drive     = DRV_IDLE;
    fin       = 1'b0;
    start_rep = 1'b0;

    if (!enable_r) begin
      // Drop any frame in flight; button words keep their contents
      phase_nxt = PH_IDLE;
      dly_nxt   = '0;
      ref_nxt   = '0;
      byte_nxt  = '0;
      bit_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_SEL_HI: begin
          drive   = DRV_IDLE;
          dly_nxt = dly_inc[15:0];
          if (bit_done) begin
            phase_nxt = PH_SEL_LO;
            dly_nxt   = '0;
          end
        end
        PH_SEL_LO: begin
          drive   = DRV_SEL_LO;
          dly_nxt = dly_inc[15:0];
          if (bit_done) begin
            byte_nxt  = '0;
            bit_nxt   = '0;
            dly_nxt   = '0;
            shift_nxt = '{default: '0};
            phase_nxt = PH_BIT_LO;
          end
        end
        PH_BIT_LO: begin
          // Command bit out with clock low; sample the pads on the last tick
          drive = {2'b00, cbit};
          if (dly_r >= bit_delay_r) begin
            for (int p = 0; p < NUM_PADS; p++) begin
              if (in_req.data_lines[p]) shift_nxt[p][bit_r] = 1'b1;
            end
            phase_nxt = PH_BIT_HI;
            dly_nxt   = '0;
          end else begin
            dly_nxt = dly_inc[15:0];
          end
        end
        PH_BIT_HI: begin
          drive   = {2'b10, cbit};
          dly_nxt = dly_inc[15:0];
          if (bit_done) begin
            dly_nxt = '0;
            if (bit_r != 3'd7) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_BIT_LO;
            end else begin
              // Byte complete: file the answer of each pad by slot
              for (int p = 0; p < NUM_PADS; p++) begin
                unique case (byte_r)
                  3'd1:    id_nxt[p]        = shift_r[p];
                  3'd2:    sts_nxt[p]       = shift_r[p];
                  3'd3:    btn_nxt[p][7:0]  = shift_r[p];
                  3'd4:    btn_nxt[p][15:8] = shift_r[p];
                  default: ;
                endcase
              end
              if (cmd_delay_r != 16'd0) phase_nxt = PH_CMD_WAIT;
              else                      fin       = 1'b1;
            end
          end
        end
        PH_CMD_WAIT: begin
          drive   = DRV_SEL_LO;
          dly_nxt = dly_inc[15:0];
          if (dly_inc >= {1'b0, cmd_delay_r}) fin = 1'b1;
        end
        PH_REPORT: begin
          // Deselect; pads with a bad id or status read as all released
          drive = DRV_IDLE;
          for (int p = 0; p < NUM_PADS; p++) begin
            if (!(id_r[p] == ID_OK && sts_r[p] == STATUS_OK)) btn_nxt[p] = BTN_RELEASED;
          end
          phase_nxt = PH_IDLE;
          dly_nxt   = '0;
          ref_nxt   = '0;
          byte_nxt  = '0;
          bit_nxt   = '0;
          start_rep = 1'b1;
        end
        default: begin
          // Idle: wait out the refresh interval, zero behaves as one
          drive   = DRV_IDLE;
          ref_nxt = ref_inc[19:0];
          if (ref_inc >= {1'b0, refresh_r}) begin
            ref_nxt   = '0;
            dly_nxt   = '0;
            phase_nxt = PH_SEL_HI;
          end
        end
      endcase

      if (fin) begin
        if (byte_r != LAST_BYTE) begin
          byte_nxt  = byte_r + 3'd1;
          bit_nxt   = '0;
          dly_nxt   = '0;
          shift_nxt = '{default: '0};
          phase_nxt = PH_BIT_LO;
        end else begin
          dly_nxt   = '0;
          phase_nxt = PH_REPORT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dly_r   <= '0;
      ref_r   <= '0;
      byte_r  <= '0;
      bit_r   <= '0;
      shift_r <= '{default: '0};
      id_r    <= '{default: '0};
      sts_r   <= '{default: '0};
      btn_r   <= '{default: BTN_RELEASED};
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      dly_r   <= dly_nxt;
      ref_r   <= ref_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      id_r    <= id_nxt;
      sts_r   <= sts_nxt;
      btn_r   <= btn_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Report unit: walk the pads, one report per free output slot
  // ---------------------------------------------------------------------------
  logic        load_rep;
  logic        load_tick;
  logic [15:0] sel_w;
  logic        sel_ok;

  assign load_rep  = rep_active_r && out_free;
  assign load_tick = in_acc && !start_rep;
  assign sel_w     = btn_r[rep_pad_r];
  assign sel_ok    = (id_r[rep_pad_r] == ID_OK) && (sts_r[rep_pad_r] == STATUS_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_active_r <= 1'b0;
      rep_pad_r    <= '0;
    end else if (in_acc && start_rep) begin
      rep_active_r <= 1'b1;
      rep_pad_r    <= '0;
    end else if (load_rep) begin
      rep_active_r <= (rep_pad_r != PAD_LAST);
      rep_pad_r    <= rep_pad_r + PAD_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic       out_valid_nxt;
  drive_t     drive_r;
  logic       rpt_r;
  logic [1:0] pad_idx_r;
  logic       pad_ok_r;
  pressed_t   pressed_r;
  axis_t      axis_x_r;
  axis_t      axis_y_r;
  logic       last_r;

  assign out_valid_nxt = load_rep || load_tick || (out_valid_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_rep) begin
      drive_r   <= DRV_IDLE;
      rpt_r     <= 1'b1;
      pad_idx_r <= 2'(rep_pad_r);
      pad_ok_r  <= sel_ok;
      pressed_r <= {~sel_w[0], ~sel_w[3], ~sel_w[15:8]};
      axis_x_r  <= axis_val(~sel_w[5], ~sel_w[7]);
      axis_y_r  <= axis_val(~sel_w[6], ~sel_w[4]);
      last_r    <= (rep_pad_r == PAD_LAST);
    end else if (load_tick) begin
      drive_r   <= drive;
      rpt_r     <= 1'b0;
      pad_idx_r <= '0;
      pad_ok_r  <= 1'b0;
      pressed_r <= '0;
      axis_x_r  <= AXIS_ZERO;
      axis_y_r  <= AXIS_ZERO;
      last_r    <= 1'b0;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.drive_lines  = drive_r;
  assign out_res.report_valid = rpt_r;
  assign out_res.pad_index    = pad_idx_r;
  assign out_res.pad_ok       = pad_ok_r;
  assign out_res.pressed      = pressed_r;
  assign out_res.axis_x       = axis_x_r;
  assign out_res.axis_y       = axis_y_r;
  assign out_res.last_report  = last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  // Hold off new ticks while reports drain
  a_no_accept_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    rep_active_r |-> !in_req.ready)
    else $error("tick request accepted while reports drain");

  // Reports go out with the port deselected
  a_report_deselected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rpt_r) |-> (drive_r == DRV_IDLE))
    else $error("report carries a non-idle line drive");

  // Only the highest pad closes a frame
  a_last_is_top_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (rpt_r && pad_idx_r == 2'(PAD_LAST)))
    else $error("last report flag on the wrong pad");

  // A report tick leaves the sequencer idle with the report unit armed
  a_report_arms_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && start_rep) |=> (rep_active_r && phase_r == PH_IDLE))
    else $error("report tick did not arm the report unit");

endmodule

>>> sim/multi_pad_serial_poller_tb.sv
module multi_pad_serial_poller_tb;
  import mpsp_pkg::*;

  localparam int PADS = 4;

  // Run length: tick requests sent in total, directed rows included
  localparam int TOTAL_TICKS = 480;

  // Hard stop, far beyond the slowest correct run
  localparam int CYCLE_LIMIT = 1000000;

  // Receiver hold-off length and drain time at the end
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 2 * PADS + 8;

  localparam int AXIS_FULL_SCALE = 255;

  // Byte slots of a frame that carry pad answers
  localparam int SLOT_ID     = 1;
  localparam int SLOT_STATUS = 2;
  localparam int SLOT_BTN_LO = 3;
  localparam int SLOT_BTN_HI = 4;

  localparam logic [7:0] POLL_CMDS [5] = '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00};

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SEL_HI, SEQ_SEL_LO, SEQ_BIT_LO, SEQ_BIT_HI, SEQ_CMD_WAIT, SEQ_REPORT
  } seq_phase_t;

  // One result as seen on out_res
  typedef struct packed {
    drive_t     drive;
    logic       rpt;
    logic [1:0] pad;
    logic       ok;
    pressed_t   pressed;
    axis_t      ax;
    axis_t      ay;
    logic       last;
  } poll_res_t;

  // Directed stimulus: either a register write or a tick request, with the
  // expected drive typed in where it is obvious
  localparam logic ROW_TICK  = 1'b0;
  localparam logic ROW_WRITE = 1'b1;

  typedef struct packed {
    logic      kind;
    cfg_idx_t  idx;
    cfg_data_t wdata;
    lines_t    lines;
    logic      typed;
    drive_t    drive;
  } dir_row_t;

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // disabled after reset: lines are ignored, port sits deselected
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hF, 1'b1, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h0, 1'b1, DRV_IDLE},
    // fastest timing; refresh of zero must act as one
    '{ROW_WRITE, CFG_REFRESH,   20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_BIT_DELAY, 20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_CMD_DELAY, 20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_ENABLE,    20'd1,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h5, 1'b1, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hA, 1'b1, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hF, 1'b1, DRV_SEL_LO},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hF, 1'b0, DRV_IDLE},
    // stretch the clock half period mid-frame, then shrink it again
    '{ROW_WRITE, CFG_BIT_DELAY, 20'd65535,   4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_BIT_DELAY, 20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h3, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hC, 1'b0, DRV_IDLE},
    // drop enable in the middle of a frame: abort, no reports
    '{ROW_WRITE, CFG_ENABLE,    20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h9, 1'b1, DRV_IDLE},
    // slowest command delay and refresh, then cut the refresh short while counting
    '{ROW_WRITE, CFG_CMD_DELAY, 20'd65535,   4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_REFRESH,   20'd1048575, 4'h0, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_ENABLE,    20'd1,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h6, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hF, 1'b0, DRV_IDLE},
    '{ROW_WRITE, CFG_REFRESH,   20'd1,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'h0, 1'b0, DRV_IDLE},
    '{ROW_TICK,  CFG_ENABLE,    20'd0,       4'hF, 1'b0, DRV_IDLE}
  };

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  mpsp_in_if  in_if ();
  mpsp_out_if out_if ();

  multi_pad_serial_poller #(
    .NUM_PADS (PADS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if.sink),
    .out_res   (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the registers
  logic        poll_en;
  logic [15:0] poll_bit_dly;
  logic [15:0] poll_cmd_dly;
  logic [19:0] poll_refresh;

  // Mirror of the sequencer
  seq_phase_t  seq_ph;
  int unsigned seq_dly;
  int unsigned seq_rcnt;
  int          seq_byte;
  int          seq_bit;
  drive_t      seq_drive;
  logic [7:0]  pad_shift  [PADS];
  logic [7:0]  pad_id     [PADS];
  logic [7:0]  pad_stat   [PADS];
  logic [15:0] pad_btn    [PADS];

  // Pads that answer properly in the frame being driven
  logic        pad_sane [PADS];

  poll_res_t   poll_results_q [$];

  int          ticks_sent   = 0;
  int          mismatches   = 0;
  int          cycle_cnt    = 0;
  int          stall_asks   = 0;
  int          stall_seen   = 0;
  int          hold_left    = 0;
  logic        quiet        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned one_min(input logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  function automatic logic cmd_bit_now();
    return POLL_CMDS[seq_byte][seq_bit];
  endfunction

  function automatic axis_t deflect(input logic plus, input logic minus);
    int v;
    v = (plus ? AXIS_FULL_SCALE : 0) - (minus ? AXIS_FULL_SCALE : 0);
    return axis_t'(v);
  endfunction

  function automatic void open_byte();
    seq_bit = 0;
    seq_dly = 0;
    foreach (pad_shift[p]) pad_shift[p] = 8'h00;
    seq_ph = SEQ_BIT_LO;
  endfunction

  function automatic void close_byte();
    if (seq_byte < SLOT_BTN_HI) begin
      seq_byte++;
      open_byte();
    end else begin
      seq_ph  = SEQ_REPORT;
      seq_dly = 0;
    end
  endfunction

  // Advance the mirrored sequencer by one tick and queue what it must emit
  function automatic void step_poller(input lines_t lines);
    poll_res_t   r;
    logic [15:0] w;
    logic        ok;
    r = '0;
    if (!poll_en) begin
      // disabled: hold everything at rest, keep the button words
      seq_ph    = SEQ_IDLE;
      seq_dly   = 0;
      seq_rcnt  = 0;
      seq_byte  = 0;
      seq_bit   = 0;
      seq_drive = DRV_IDLE;
      r.drive   = DRV_IDLE;
      poll_results_q.push_back(r);
      return;
    end
    case (seq_ph)
      SEQ_SEL_HI: begin
        seq_drive = DRV_IDLE;
        seq_dly++;
        if (seq_dly >= one_min(poll_bit_dly)) begin
          seq_ph  = SEQ_SEL_LO;
          seq_dly = 0;
        end
      end
      SEQ_SEL_LO: begin
        seq_drive = DRV_SEL_LO;
        seq_dly++;
        if (seq_dly >= one_min(poll_bit_dly)) begin
          seq_byte = 0;
          open_byte();
        end
      end
      SEQ_BIT_LO: begin
        // clock low; sample the lines on the last tick of the half period
        seq_drive = {2'b00, cmd_bit_now()};
        if (seq_dly >= poll_bit_dly) begin
          for (int p = 0; p < PADS; p++) begin
            if (lines[p]) pad_shift[p][seq_bit] = 1'b1;
          end
          seq_ph  = SEQ_BIT_HI;
          seq_dly = 0;
        end else begin
          seq_dly++;
        end
      end
      SEQ_BIT_HI: begin
        seq_drive = DRV_SEL_LO | {2'b00, cmd_bit_now()};
        seq_dly++;
        if (seq_dly >= one_min(poll_bit_dly)) begin
          seq_dly = 0;
          if (seq_bit < 7) begin
            seq_bit++;
            seq_ph = SEQ_BIT_LO;
          end else begin
            for (int p = 0; p < PADS; p++) begin
              case (seq_byte)
                SLOT_ID:     pad_id[p]          = pad_shift[p];
                SLOT_STATUS: pad_stat[p]        = pad_shift[p];
                SLOT_BTN_LO: pad_btn[p][7:0]    = pad_shift[p];
                SLOT_BTN_HI: pad_btn[p][15:8]   = pad_shift[p];
                default: ;
              endcase
            end
            if (poll_cmd_dly != 16'd0) seq_ph = SEQ_CMD_WAIT;
            else close_byte();
          end
        end
      end
      SEQ_CMD_WAIT: begin
        seq_drive = DRV_SEL_LO;
        seq_dly++;
        if (seq_dly >= poll_cmd_dly) close_byte();
      end
      SEQ_REPORT: begin
        // one report per pad; a pad with a bad id or status reads as released
        seq_drive = DRV_IDLE;
        for (int p = 0; p < PADS; p++) begin
          ok = (pad_id[p] == ID_OK) && (pad_stat[p] == STATUS_OK);
          if (!ok) pad_btn[p] = BTN_RELEASED;
          w         = pad_btn[p];
          r         = '0;
          r.drive   = DRV_IDLE;
          r.rpt     = 1'b1;
          r.pad     = 2'(p);
          r.ok      = ok;
          r.pressed = {~w[0], ~w[3], ~w[15:8]};
          r.ax      = deflect(~w[5], ~w[7]);
          r.ay      = deflect(~w[6], ~w[4]);
          r.last    = (p == PADS - 1);
          poll_results_q.push_back(r);
          // pick how this pad answers in the next frame
          pad_sane[p] = ($urandom_range(99) < 80);
        end
        seq_ph   = SEQ_IDLE;
        seq_dly  = 0;
        seq_rcnt = 0;
        seq_byte = 0;
        seq_bit  = 0;
        return;
      end
      default: begin
        seq_drive = DRV_IDLE;
        seq_rcnt++;
        if (seq_rcnt >= poll_refresh) begin
          seq_rcnt = 0;
          seq_ph   = SEQ_SEL_HI;
          seq_dly  = 0;
        end
      end
    endcase
    r.drive = seq_drive;
    poll_results_q.push_back(r);
  endfunction

  // Choose the data lines of the next tick: on a sampling tick a sane pad
  // answers with the right id and status and random buttons
  function automatic lines_t pick_lines();
    lines_t v;
    v = lines_t'($urandom);
    if (poll_en && seq_ph == SEQ_BIT_LO && seq_dly >= poll_bit_dly) begin
      for (int p = 0; p < PADS; p++) begin
        if (pad_sane[p]) begin
          case (seq_byte)
            SLOT_ID:     v[p] = ID_OK[seq_bit];
            SLOT_STATUS: v[p] = STATUS_OK[seq_bit];
            SLOT_BTN_LO,
            SLOT_BTN_HI: v[p] = ($urandom_range(99) >= 25);
            default: ;
          endcase
        end
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Stop offering requests and wait until every expected result has come
  task automatic settle();
    in_if.valid <= 1'b0;
    while (poll_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:    poll_en      = val[0];
      CFG_BIT_DELAY: poll_bit_dly = val[15:0];
      CFG_CMD_DELAY: poll_cmd_dly = val[15:0];
      CFG_REFRESH:   poll_refresh = val[19:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one tick request, hold it until accepted, then advance the mirror
  task automatic send_tick(input lines_t lines, input logic typed, input drive_t drv);
    poll_res_t want;
    in_if.valid      <= 1'b1;
    in_if.data_lines <= lines;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    ticks_sent++;
    step_poller(lines);
    if (typed) begin
      // replace the prediction with the value read off directly
      void'(poll_results_q.pop_back());
      want       = '0;
      want.drive = drv;
      poll_results_q.push_back(want);
    end
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (!quiet && $urandom_range(99) < 16) begin
        in_if.valid      <= 1'b0;
        in_if.data_lines <= lines_t'($urandom);
        repeat ($urandom_range(1, 2)) @(posedge clk);
      end
      send_tick(pick_lines(), 1'b0, DRV_IDLE);
    end
  endtask

  initial begin
    dir_row_t  row;
    int        phase_no;
    int        n_tick;
    cfg_data_t bd;
    cfg_data_t cd;
    cfg_data_t rf;

    // drive every input known from time zero and hold reset
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ENABLE;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.data_lines = '0;

    // mirror the reset state
    poll_en      = 1'b0;
    poll_bit_dly = BIT_DELAY_RST;
    poll_cmd_dly = CMD_DELAY_RST;
    poll_refresh = REFRESH_RST;
    seq_ph       = SEQ_IDLE;
    seq_dly      = 0;
    seq_rcnt     = 0;
    seq_byte     = 0;
    seq_bit      = 0;
    seq_drive    = DRV_IDLE;
    for (int p = 0; p < PADS; p++) begin
      pad_shift[p]  = 8'h00;
      pad_id[p]     = 8'h00;
      pad_stat[p]   = 8'h00;
      pad_btn[p]    = BTN_RELEASED;
      pad_sane[p]   = 1'b1;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.wdata);
      else send_tick(row.lines, row.typed, row.drive);
    end

    // Random phases: new timing each phase, mostly fast enough for full
    // frames; each phase ends wherever it ends, so the next write often lands
    // mid-frame. Every ninth phase runs disabled.
    phase_no = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      bd = cfg_data_t'(($urandom_range(99) < 80) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 9));
      cd = cfg_data_t'(($urandom_range(99) < 80) ? $urandom_range(0, 3)
                                                 : $urandom_range(4, 25));
      rf = cfg_data_t'(($urandom_range(99) < 80) ? $urandom_range(0, 6)
                                                 : $urandom_range(7, 60));
      write_reg(CFG_BIT_DELAY, bd);
      write_reg(CFG_CMD_DELAY, cd);
      write_reg(CFG_REFRESH, rf);
      write_reg(CFG_ENABLE, (phase_no % 9 == 8) ? 20'd0 : 20'd1);

      // one phase without idling on either side
      quiet <= (phase_no == 2);

      // hold off the receiver for a long stretch while requests keep coming
      if (phase_no == 3 || phase_no % 7 == 5) stall_asks <= stall_asks + 1;

      if (phase_no % 9 == 8) n_tick = 20;
      else n_tick = int'($urandom_range(30, 90));
      if (n_tick > TOTAL_TICKS - ticks_sent) n_tick = TOTAL_TICKS - ticks_sent;
      send_random(n_tick);
      phase_no++;
    end

    // drain, let the block go quiet, then judge
    settle();
    quiet <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && poll_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Long receiver hold-off, counted here on each request from the stimulus
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (stall_asks != stall_seen) begin
      hold_left  <= HOLD_CYCLES;
      stall_seen <= stall_asks;
    end
  end

  // Random receiver idling, none during a hold-off or a quiet phase
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 16);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    poll_res_t got;
    poll_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.drive   = out_if.drive_lines;
      got.rpt     = out_if.report_valid;
      got.pad     = out_if.pad_index;
      got.ok      = out_if.pad_ok;
      got.pressed = out_if.pressed;
      got.ax      = out_if.axis_x;
      got.ay      = out_if.axis_y;
      got.last    = out_if.last_report;
      if (poll_results_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0d] unexpected result: drive %0d report %0b pad %0d",
                   cycle_cnt, got.drive, got.rpt, got.pad);
        mismatches++;
      end else begin
        want = poll_results_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("[%0d] mismatch (exp/act): drive %0d/%0d report %0b/%0b pad %0d/%0d",
                     cycle_cnt, want.drive, got.drive, want.rpt, got.rpt,
                     want.pad, got.pad);
            $display("  ok %0b/%0b pressed %h/%h x %0d/%0d y %0d/%0d last %0b/%0b",
                     want.ok, got.ok, want.pressed, got.pressed,
                     $signed(want.ax), $signed(got.ax), $signed(want.ay), $signed(got.ay),
                     want.last, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/mpsp_pkg.sv
rtl/mpsp_in_if.sv
rtl/mpsp_out_if.sv
rtl/multi_pad_serial_poller.sv
sim/multi_pad_serial_poller_tb.sv
